FILE: hdl/mcit_pkg.sv
package mcit_pkg;

  // Operation codes of an input word.
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // At most this many firings are reported per tick.
  localparam int unsigned MAX_RES = 16;
  localparam int unsigned CNT_W   = 5;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  channel;
    logic [30:0] timeout;
    logic        repeat_req;
  } mcit_in_t;

  typedef struct packed {
    logic        fired_valid;
    logic [3:0]  fired_channel;
    logic        any_active;
    logic [31:0] next_deadline;
    logic        last;
  } mcit_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_en;
    logic emit_step;
  } mcit_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
    logic emit_last;
  } mcit_sts_t;

endpackage

FILE: hdl/mcit_ctrl.sv
module mcit_ctrl
  import mcit_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  mcit_sts_t sts_i,
  output mcit_cmd_t cmd_o,
  output logic      busy_o,
  output logic      res_valid_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit_step = 1'b1;
        if (sts_i.emit_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_EMIT);

endmodule

FILE: hdl/mcit_dp.sv
module mcit_dp
  import mcit_pkg::*;
#(
  parameter int unsigned NUM_TIMERS = 16,
  parameter int unsigned TIME_BITS  = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  mcit_cmd_t cmd_i,
  input  mcit_in_t  item_i,
  output mcit_sts_t sts_o,
  output mcit_out_t res_o
);

  localparam int unsigned IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned CW    = IDX_W + 4;

  // Channel table. Only the armed flags need a reset value.
  logic [NUM_TIMERS-1:0] armed_q;
  logic [TIME_BITS-1:0]  deadline_q [NUM_TIMERS];
  logic [30:0]           period_q   [NUM_TIMERS];
  logic                  periodic_q [NUM_TIMERS];

  logic [TIME_BITS-1:0] now_q;
  logic [1:0]           op_q;
  logic [IDX_W-1:0]     idx_q;

  // List of fired channels for the current tick.
  logic [3:0]       fired_list_q [MAX_RES];
  logic [CNT_W-1:0] fired_cnt_q;
  logic [CNT_W-1:0] emit_q;

  // Second scan stage: the entry as it stands after this item.
  logic                 b_valid_q;
  logic                 b_armed_q;
  logic [TIME_BITS-1:0] b_dl_q;

  // Running minimum of the armed deadlines.
  logic                 found_q;
  logic [TIME_BITS-1:0] best_key_q;
  logic [TIME_BITS-1:0] best_dl_q;

  // Load-time decode of the command word.
  logic [CW-1:0]    chan_w;
  logic             chan_ok;
  logic [IDX_W-1:0] chan_idx;

  assign chan_w   = {{IDX_W{1'b0}}, item_i.channel};
  assign chan_ok  = (chan_w < CW'(NUM_TIMERS));
  assign chan_idx = chan_w[IDX_W-1:0];

  // First scan stage: expiry test and deadline update of entry idx_q.
  logic                 a_armed;
  logic [TIME_BITS-1:0] a_dl;
  logic [30:0]          a_per;
  logic                 a_periodic;
  logic [TIME_BITS-1:0] a_diff;
  logic                 a_fire;
  logic [TIME_BITS-1:0] a_new_dl;

  assign a_armed    = armed_q[idx_q];
  assign a_dl       = deadline_q[idx_q];
  assign a_per      = period_q[idx_q];
  assign a_periodic = periodic_q[idx_q];
  assign a_diff     = now_q - a_dl;
  assign a_fire     = (op_q == OP_TICK) && a_armed && (a_diff != '0) &&
                      !a_diff[TIME_BITS-1];
  assign a_new_dl   = (a_per == '0) ? now_q : (a_dl + TIME_BITS'(a_per));

  // Keys shifted by half the range so that an unsigned compare gives signed order.
  logic [TIME_BITS-1:0] b_off;
  logic [TIME_BITS-1:0] b_key;

  assign b_off = b_dl_q - now_q;
  assign b_key = {~b_off[TIME_BITS-1], b_off[TIME_BITS-2:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= '0;
      now_q   <= '0;
    end else if (cmd_i.load) begin
      if (item_i.op == OP_TICK) begin
        now_q <= now_q + TIME_BITS'(1);
      end
      if (item_i.op == OP_START && chan_ok) begin
        armed_q[chan_idx] <= 1'b1;
      end
      if (item_i.op == OP_STOP && chan_ok) begin
        armed_q[chan_idx] <= 1'b0;
      end
    end else if (cmd_i.scan_en && a_fire && !a_periodic) begin
      armed_q[idx_q] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (item_i.op == OP_START && chan_ok) begin
        deadline_q[chan_idx] <= now_q + TIME_BITS'(item_i.timeout);
        period_q[chan_idx]   <= item_i.timeout;
        periodic_q[chan_idx] <= item_i.repeat_req;
      end
    end else if (cmd_i.scan_en && a_fire && a_periodic) begin
      deadline_q[idx_q] <= a_new_dl;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_en && a_fire && (fired_cnt_q < CNT_W'(MAX_RES))) begin
      fired_list_q[fired_cnt_q[3:0]] <= 4'(idx_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q        <= OP_START;
      idx_q       <= '0;
      fired_cnt_q <= '0;
      emit_q      <= '0;
      b_valid_q   <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      b_valid_q <= cmd_i.scan_en;
      if (cmd_i.load) begin
        op_q        <= item_i.op;
        idx_q       <= '0;
        fired_cnt_q <= '0;
        emit_q      <= '0;
        found_q     <= 1'b0;
      end else begin
        if (cmd_i.scan_en) begin
          if (!sts_o.scan_last) begin
            idx_q <= idx_q + IDX_W'(1);
          end
          if (a_fire && (fired_cnt_q < CNT_W'(MAX_RES))) begin
            fired_cnt_q <= fired_cnt_q + CNT_W'(1);
          end
        end
        if (b_valid_q && b_armed_q && (!found_q || (b_key < best_key_q))) begin
          found_q <= 1'b1;
        end
        if (cmd_i.emit_step) begin
          emit_q <= emit_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_en) begin
      b_armed_q <= a_armed && !(a_fire && !a_periodic);
      b_dl_q    <= (a_fire && a_periodic) ? a_new_dl : a_dl;
    end
    if (b_valid_q && b_armed_q && (!found_q || (b_key < best_key_q))) begin
      best_key_q <= b_key;
      best_dl_q  <= b_dl_q;
    end
  end

  assign sts_o.scan_last = (idx_q == IDX_W'(NUM_TIMERS - 1));
  assign sts_o.emit_last = (fired_cnt_q == '0) || (emit_q == fired_cnt_q - CNT_W'(1));

  assign res_o.fired_valid   = (fired_cnt_q != '0);
  assign res_o.fired_channel = (fired_cnt_q != '0) ? fired_list_q[emit_q[3:0]] : 4'd0;
  assign res_o.any_active    = found_q;
  assign res_o.next_deadline = found_q ? 32'(best_dl_q) : 32'd0;
  assign res_o.last          = sts_o.emit_last;

endmodule

FILE: hdl/multi_channel_interval_timer.sv
// Multi-channel interval timer.
//
// A command word is taken on start_i while busy_o is low. Its op field
// starts a channel (deadline = now + timeout), stops a channel, or ticks
// the millisecond counter by one and checks every channel for expiry.
// Start and stop on a channel at or above NUM_TIMERS change nothing.
//
// Results come out as words on res_o, one per cycle, each marked by a
// single-cycle res_valid_o strobe. A tick gives one word per fired channel
// in index order (at most 16 reported), or one with fired_valid low if none
// fired; any other command gives one such word. The last word of a command
// has last set, and every word carries the armed flag and earliest deadline
// after the command. The receiver cannot stall, so results are never held.
//
// Sequence: every command walks the whole channel table through a two-stage
// scan, one channel per cycle, and a drain state before the first result
// word is on res_o. busy_o stays high from the accepting edge until the
// edge that ends the last word, so the next command is taken only after
// all result words of the previous one. Reset clears the time counter and
// disarms every channel.
module multi_channel_interval_timer
  import mcit_pkg::*;
#(
  parameter int unsigned NUM_TIMERS = 16,
  parameter int unsigned TIME_BITS  = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  mcit_in_t  item_i,
  output logic      busy_o,
  output logic      res_valid_o,
  output mcit_out_t res_o
);

  mcit_cmd_t cmd;
  mcit_sts_t sts;

  // Sequencer: idle, table scan, pipeline drain, result emission.
  mcit_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o)
  );

  // Channel table, time counter, fired list and earliest-deadline tracker.
  mcit_dp #(
    .NUM_TIMERS (NUM_TIMERS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .item_i (item_i),
    .sts_o  (sts),
    .res_o  (res_o)
  );

endmodule

FILE: hdl/mcit_checker.sv
module mcit_checker
  import mcit_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start_i,
  input logic      busy_o,
  input logic      res_valid_o,
  input mcit_out_t res_o
);

  // Results only appear while a command is in progress.
  a_res_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy_o)
    else $error("result word while idle");

  // An accepted command makes the block busy.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("not busy after accept");

  // The last word of a command is followed by an idle cycle.
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last) |=> !res_valid_o)
    else $error("result word right after last");

  // A word without a firing is the only word of its command.
  a_plain_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.fired_valid) |-> (res_o.last && res_o.fired_channel == 4'd0))
    else $error("non-fired word not alone");

  // With nothing armed the deadline reads as zero.
  a_idle_deadline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.any_active) |-> (res_o.next_deadline == 32'd0))
    else $error("deadline reported with nothing armed");

endmodule

bind multi_channel_interval_timer mcit_checker u_mcit_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

FILE: verif/tb_multi_channel_interval_timer.sv
`timescale 1ns / 1ps

module tb_multi_channel_interval_timer;
  import mcit_pkg::*;

  // The package names three ops; the fourth code only reports status.
  localparam logic [1:0]  OP_NONE      = 2'd3;
  localparam int unsigned NUM_CH       = 16;
  localparam logic [31:0] HALF_RANGE   = 32'h8000_0000;
  // One command walks the table and then emits up to MAX_RES words.
  localparam int unsigned DRAIN_CYCLES = NUM_CH + 2 + MAX_RES + 4;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned RANDOM_WORDS = 400;

  logic      clk_i;
  logic      rst_ni;
  logic      start_i;
  mcit_in_t  item_i;
  logic      busy_o;
  logic      res_valid_o;
  mcit_out_t res_o;

  // A directed row may carry a hand-written result. It travels with the
  // command word so that the monitor sees it at the edge that accepts it.
  logic      fixed_valid;
  mcit_out_t fixed_word;

  typedef struct {
    mcit_in_t  word;
    bit        typed;
    mcit_out_t want;
  } dir_row_t;

  dir_row_t    dir_rows[$];
  mcit_out_t   expected_words[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;

  // Timer state as the block should hold it.
  logic [31:0] tm_now;
  bit          tm_armed    [NUM_CH];
  logic [31:0] tm_deadline [NUM_CH];
  logic [30:0] tm_period   [NUM_CH];
  bit          tm_periodic [NUM_CH];

  multi_channel_interval_timer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .item_i      (item_i),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic mcit_in_t cmd_word(logic [1:0] op, logic [3:0] ch, logic [30:0] tmo,
                                        logic rep);
    mcit_in_t w;
    w.op         = op;
    w.channel    = ch;
    w.timeout    = tmo;
    w.repeat_req = rep;
    return w;
  endfunction

  function automatic mcit_out_t status_word(logic fv, logic [3:0] ch, logic any,
                                            logic [31:0] nd, logic lst);
    mcit_out_t w;
    w.fired_valid   = fv;
    w.fired_channel = ch;
    w.any_active    = any;
    w.next_deadline = nd;
    w.last          = lst;
    return w;
  endfunction

  // Wrap-aware time order: a lies before b when b - a is nonzero and in
  // the lower half of the range.
  function automatic bit lies_before(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = b - a;
    return (d != 32'd0) && (d < HALF_RANGE);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic reset_timer_state();
    tm_now = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      tm_armed[i]    = 1'b0;
      tm_deadline[i] = '0;
      tm_period[i]   = '0;
      tm_periodic[i] = 1'b0;
    end
  endtask

  // Appends one word to the end of the expectation queue.
  task automatic queue_expected(mcit_out_t w);
    expected_words.insert(expected_words.size(), w);
  endtask

  // Applies one accepted command to the timer state and queues the words
  // that it must produce. A hand-written result replaces the computed one.
  task automatic predict_timer_words(mcit_in_t w, bit use_fixed, mcit_out_t fixed);
    logic [3:0]  fired_ch [MAX_RES];
    int unsigned n_fired;
    bit          found;
    logic [31:0] key;
    logic [31:0] best_key;
    logic [31:0] best_dl;
    n_fired  = 0;
    found    = 1'b0;
    best_key = '0;
    best_dl  = '0;
    case (w.op)
      OP_START: begin
        if (int'(w.channel) < NUM_CH) begin
          tm_period[w.channel]   = w.timeout;
          tm_periodic[w.channel] = w.repeat_req;
          tm_deadline[w.channel] = tm_now + {1'b0, w.timeout};
          tm_armed[w.channel]    = 1'b1;
        end
      end
      OP_STOP: begin
        if (int'(w.channel) < NUM_CH) tm_armed[w.channel] = 1'b0;
      end
      OP_TICK: begin
        tm_now = tm_now + 32'd1;
        for (int i = 0; i < NUM_CH; i++) begin
          if (tm_armed[i] && lies_before(tm_deadline[i], tm_now)) begin
            // Every expired channel is updated, but only MAX_RES are reported.
            if (n_fired < MAX_RES) begin
              fired_ch[n_fired] = 4'(i);
              n_fired++;
            end
            if (!tm_periodic[i]) begin
              tm_armed[i] = 1'b0;
            end else if (tm_period[i] == '0) begin
              tm_deadline[i] = tm_now;
            end else begin
              // Moved on once per tick; a late channel fires again next tick.
              tm_deadline[i] = tm_deadline[i] + {1'b0, tm_period[i]};
            end
          end
        end
      end
      default: begin
      end
    endcase
    // Earliest deadline by signed offset from now; the lower index wins a tie.
    for (int i = 0; i < NUM_CH; i++) begin
      if (tm_armed[i]) begin
        key = tm_deadline[i] - tm_now + HALF_RANGE;
        if (!found || key < best_key) begin
          found    = 1'b1;
          best_key = key;
          best_dl  = tm_deadline[i];
        end
      end
    end
    if (use_fixed) begin
      queue_expected(fixed);
    end else if (n_fired == 0) begin
      queue_expected(status_word(1'b0, 4'd0, found, best_dl, 1'b1));
    end else begin
      for (int k = 0; k < n_fired; k++) begin
        queue_expected(status_word(1'b1, fired_ch[k], found, best_dl,
                                   k == n_fired - 1));
      end
    end
  endtask

  // Checks each result word against the oldest expectation, then predicts
  // the command accepted at this edge. A command is never accepted on the
  // same edge as one of its own words, since busy_o covers the whole walk.
  always @(posedge clk_i) begin : monitor
    mcit_out_t want;
    bit        moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (res_valid_o) begin
        moved = 1'b1;
        if (expected_words.size() == 0) begin
          report_mismatch("word with nothing expected", res_o.next_deadline, 32'd0);
        end else begin
          want = expected_words.pop_front();
          if (res_o.fired_valid !== want.fired_valid)
            report_mismatch("fired_valid", 32'(res_o.fired_valid), 32'(want.fired_valid));
          if (res_o.fired_channel !== want.fired_channel)
            report_mismatch("fired_channel", 32'(res_o.fired_channel),
                            32'(want.fired_channel));
          if (res_o.any_active !== want.any_active)
            report_mismatch("any_active", 32'(res_o.any_active), 32'(want.any_active));
          if (res_o.next_deadline !== want.next_deadline)
            report_mismatch("next_deadline", res_o.next_deadline, want.next_deadline);
          if (res_o.last !== want.last)
            report_mismatch("last", 32'(res_o.last), 32'(want.last));
        end
      end
      if (start_i && !busy_o) begin
        moved = 1'b1;
        predict_timer_words(item_i, fixed_valid, fixed_word);
      end
    end
    idle_cycles <= moved ? 0 : idle_cycles + 1;
  end

  // Ends the run when neither a command nor a result word has moved for
  // far longer than the slowest command plus the longest sender gap.
  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("tb_multi_channel_interval_timer NOT OK");
    $finish;
  end

  // Presents one command word and returns at the edge that accepts it.
  // start_i stays high, so a following word goes out with no dead cycle.
  task automatic send_word(mcit_in_t w, bit typed, mcit_out_t want);
    start_i     <= 1'b1;
    item_i      <= w;
    fixed_valid <= typed;
    fixed_word  <= want;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Holds the sender off until every expected word has come back.
  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic add_row(mcit_in_t w, bit typed, mcit_out_t want);
    dir_row_t row;
    row.word  = w;
    row.typed = typed;
    row.want  = want;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // Random command. Most starts use short timeouts so that channels expire
  // often; fields that an op ignores carry random noise.
  function automatic mcit_in_t rand_word();
    mcit_in_t    w;
    int unsigned pick;
    w.channel    = 4'($urandom_range(0, 15));
    w.repeat_req = 1'($urandom_range(0, 1));
    w.timeout    = 31'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 38)      w.op = OP_TICK;
    else if (pick < 75) w.op = OP_START;
    else if (pick < 93) w.op = OP_STOP;
    else                w.op = OP_NONE;
    if (w.op == OP_START) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      w.timeout = 31'($urandom_range(0, 6));
      else if (pick < 80) w.timeout = '1;
      else if (pick < 88) w.timeout = 31'h4000_0000 + 31'($urandom_range(0, 6));
    end
    return w;
  endfunction

  initial begin : stimulus
    mcit_in_t    w;
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    bit          paused;
    start_i     <= 1'b0;
    item_i      <= '0;
    fixed_valid <= 1'b0;
    fixed_word  <= '0;
    rst_ni      <= 1'b0;
    reset_timer_state();

    // Status after reset, the unused op and an empty tick are known by hand,
    // as is arming with the longest timeout and a zero-period channel.
    add_row(cmd_word(OP_STOP, 4'd0, 31'd0, 1'b0), 1'b1,
            status_word(1'b0, 4'd0, 1'b0, 32'd0, 1'b1));
    add_row(cmd_word(OP_NONE, 4'd15, '1, 1'b1), 1'b1,
            status_word(1'b0, 4'd0, 1'b0, 32'd0, 1'b1));
    add_row(cmd_word(OP_TICK, 4'd0, 31'd0, 1'b0), 1'b1,
            status_word(1'b0, 4'd0, 1'b0, 32'd0, 1'b1));
    add_row(cmd_word(OP_START, 4'd15, '1, 1'b0), 1'b1,
            status_word(1'b0, 4'd0, 1'b1, 32'h8000_0000, 1'b1));
    add_row(cmd_word(OP_START, 4'd0, 31'd0, 1'b1), 1'b1,
            status_word(1'b0, 4'd0, 1'b1, 32'd1, 1'b1));
    // The zero-period channel fires on every tick.
    add_row(cmd_word(OP_TICK, 4'd0, 31'd0, 1'b0), 1'b0, '0);
    add_row(cmd_word(OP_TICK, 4'd5, 31'h7, 1'b1), 1'b0, '0);
    // A one-shot channel and two periodic channels that share a deadline.
    add_row(cmd_word(OP_START, 4'd3, 31'd1, 1'b0), 1'b0, '0);
    add_row(cmd_word(OP_START, 4'd9, 31'd3, 1'b1), 1'b0, '0);
    add_row(cmd_word(OP_START, 4'd8, 31'd3, 1'b1), 1'b0, '0);
    for (int i = 0; i < 4; i++) add_row(cmd_word(OP_TICK, 4'd0, 31'd0, 1'b0), 1'b0, '0);
    // Re-arm a running periodic channel as a one-shot, stop twice.
    add_row(cmd_word(OP_START, 4'd9, 31'd10, 1'b0), 1'b0, '0);
    add_row(cmd_word(OP_STOP, 4'd0, 31'd0, 1'b0), 1'b0, '0);
    add_row(cmd_word(OP_STOP, 4'd0, '1, 1'b1), 1'b0, '0);
    add_row(cmd_word(OP_START, 4'd15, 31'd0, 1'b0), 1'b0, '0);
    add_row(cmd_word(OP_TICK, 4'd0, 31'd0, 1'b0), 1'b0, '0);
    add_row(cmd_word(OP_START, 4'd1, 31'h2AAA_AAAA, 1'b1), 1'b0, '0);
    add_row(cmd_word(OP_START, 4'd2, 31'h5555_5555, 1'b0), 1'b0, '0);
    add_row(cmd_word(OP_TICK, 4'd10, 31'h1234_5678, 1'b1), 1'b0, '0);
    add_row(cmd_word(OP_STOP, 4'd15, 31'd0, 1'b0), 1'b0, '0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
    wait_drained();

    // Random part: bursts of words with random gaps, now and then a storm
    // that arms every channel with the same timeout so that a single tick fires them all.
    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 99) < 4) begin
        for (int ch = 0; ch < NUM_CH; ch++)
          send_word(cmd_word(OP_START, 4'(ch), 31'd1, 1'($urandom_range(0, 1))), 1'b0, '0);
        for (int k = 0; k < 2; k++)
          send_word(cmd_word(OP_TICK, 4'($urandom), 31'($urandom), 1'($urandom)), 1'b0, '0);
        sent += NUM_CH + 2;
      end else begin
        burst = $urandom_range(1, 20);
        for (int k = 0; k < burst; k++) begin
          w = rand_word();
          send_word(w, 1'b0, '0);
          if (w.op != OP_NONE) sent++;
        end
      end
      if (!paused && sent >= RANDOM_WORDS / 2) begin
        wait_drained();
        paused = 1'b1;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        if (gap != 0) begin
          start_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end

    wait_drained();
    // Any stray word would show up within one more walk of the table.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_multi_channel_interval_timer OK");
    end else begin
      $display("tb_multi_channel_interval_timer NOT OK");
    end
    $finish;
  end

endmodule
